/* rtl/spq_pkg.sv */
package spq_pkg;

    // field widths of one word
    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 32;
    localparam int ENTRY_W = VALUE_W + PRIO_W;

    // result flag positions in m_tuser
    localparam int FLAG_POPPED  = 0;
    localparam int FLAG_DROPPED = 1;
    localparam int FLAG_EMPTY   = 2;
    localparam int FLAGS_W      = 3;

    // operation codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_POP       = 2'd0,
        OP_PUSH_HEAD = 2'd1,
        OP_INSERT    = 2'd2
    } op_t;

    // commands from controller to datapath
    typedef struct packed {
        logic latch_in;   // capture input word, clear pending result
        logic set_drop;   // push found the queue full
        logic pop_rd;     // read head entry
        logic pop_take;   // return head entry, advance head
        logic head_push;  // write new entry in front of head
        logic scan_rd;    // read entry at scan index
        logic scan_next;  // step scan index
        logic scan_stop;  // keep insert position, start shift at tail
        logic shift_rd;   // read entry below shift index
        logic shift_wr;   // move read entry up by one place
        logic ins_wr;     // write new entry at insert position
        logic out_load;   // move pending result to output register
    } spq_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic scan_end;   // scan index reached the entry count
        logic shift_end;  // shift index reached the insert position
        logic precedes;   // read entry strictly precedes the new one
        logic out_busy;   // output register holds an untaken result
    } spq_status_t;

endpackage

/* rtl/spq_ram.sv */
module spq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     ren,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (ren) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/spq_ctrl.sv */
module spq_ctrl import spq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  op_t         in_op,
    output logic        in_ready,
    input  spq_status_t status,
    output spq_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_WAIT,
        ST_HEAD_PUSH,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // command decode and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.latch_in = 1'b1;
                    unique case (in_op)
                        OP_POP: begin
                            if (status.empty) begin
                                state_next = ST_FINISH;
                            end else begin
                                cmd.pop_rd = 1'b1;
                                state_next = ST_POP_WAIT;
                            end
                        end
                        OP_PUSH_HEAD: begin
                            if (status.full) begin
                                cmd.set_drop = 1'b1;
                                state_next   = ST_FINISH;
                            end else begin
                                state_next = ST_HEAD_PUSH;
                            end
                        end
                        OP_INSERT: begin
                            if (status.full) begin
                                cmd.set_drop = 1'b1;
                                state_next   = ST_FINISH;
                            end else begin
                                state_next = ST_SCAN_RD;
                            end
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_POP_WAIT: begin
                cmd.pop_take = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_HEAD_PUSH: begin
                cmd.head_push = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_SCAN_RD: begin
                if (status.scan_end) begin
                    cmd.scan_stop = 1'b1;
                    state_next    = ST_SHIFT_RD;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                if (status.precedes) begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_SCAN_RD;
                end else begin
                    cmd.scan_stop = 1'b1;
                    state_next    = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD: begin
                if (status.shift_end) begin
                    cmd.ins_wr = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    cmd.shift_rd = 1'b1;
                    state_next   = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = ST_SHIFT_RD;
            end
            ST_FINISH: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/spq_datapath.sv */
module spq_datapath import spq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  spq_cmd_t           cmd,
    output spq_status_t        status,
    input  logic [ENTRY_W-1:0] s_tdata,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [VALUE_W-1:0] m_tdata,
    output logic [FLAGS_W-1:0] m_tuser
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = CW + 1;

    logic [AW-1:0]      head_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      pos_reg;
    logic               asc_reg;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [PRIO_W-1:0]  pri_reg;
    logic [VALUE_W-1:0] res_value_reg;
    logic               res_valid_reg;
    logic               res_drop_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [FLAGS_W-1:0] out_flags_reg;

    logic [AW-1:0]      head_inc;
    logic [AW-1:0]      head_dec;
    logic [CW-1:0]      rd_index;
    logic [PRIO_W-1:0]  held_pri;

    logic               ram_ren;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;

    // place in ring of a position counted from the head
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                                input logic [CW-1:0] l);
        logic [PW-1:0] sum;
        sum = PW'(head) + PW'(l);
        if (sum >= PW'(QUEUE_DEPTH)) begin
            sum = sum - PW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // head pointer steps with wrap
    assign head_inc = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? AW'(QUEUE_DEPTH - 1) : head_reg - AW'(1);

    // memory port selection
    always_comb begin
        ram_ren = cmd.pop_rd | cmd.scan_rd | cmd.shift_rd;
        priority if (cmd.pop_rd) begin
            rd_index = '0;
        end else if (cmd.scan_rd) begin
            rd_index = idx_reg;
        end else begin
            rd_index = idx_reg - CW'(1);
        end
        ram_raddr = ring_addr(head_reg, rd_index);

        ram_we = cmd.head_push | cmd.shift_wr | cmd.ins_wr;
        priority if (cmd.head_push) begin
            ram_waddr = head_dec;
        end else if (cmd.shift_wr) begin
            ram_waddr = ring_addr(head_reg, idx_reg);
        end else begin
            ram_waddr = ring_addr(head_reg, pos_reg);
        end
        ram_wdata = cmd.shift_wr ? ram_rdata : {pri_reg, val_reg};
    end

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .ren   (ram_ren),
        .raddr (ram_raddr),
        .rdata (ram_rdata),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata)
    );

    // order test on the entry just read
    assign held_pri = ram_rdata[ENTRY_W-1:VALUE_W];

    always_comb begin
        status.empty     = (count_reg == '0);
        status.full      = (count_reg == CW'(QUEUE_DEPTH));
        status.scan_end  = (idx_reg == count_reg);
        status.shift_end = (idx_reg == pos_reg);
        status.precedes  = asc_reg ? (held_pri < pri_reg) : (held_pri > pri_reg);
        status.out_busy  = out_valid_reg & ~m_tready;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            asc_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                asc_reg <= cfg_wr_data;
            end
            if (cmd.latch_in) begin
                idx_reg <= '0;
            end
            if (cmd.pop_take) begin
                head_reg  <= head_inc;
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.head_push) begin
                head_reg  <= head_dec;
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.scan_next) begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.scan_stop) begin
                pos_reg <= idx_reg;
                idx_reg <= count_reg;
            end
            if (cmd.shift_wr) begin
                idx_reg <= idx_reg - CW'(1);
            end
            if (cmd.ins_wr) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // word and result payload
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            val_reg       <= s_tdata[VALUE_W-1:0];
            pri_reg       <= s_tdata[ENTRY_W-1:VALUE_W];
            res_value_reg <= '0;
            res_valid_reg <= 1'b0;
            res_drop_reg  <= cmd.set_drop;
        end
        if (cmd.pop_take) begin
            res_value_reg <= ram_rdata[VALUE_W-1:0];
            res_valid_reg <= 1'b1;
        end
        if (cmd.out_load) begin
            out_value_reg               <= res_value_reg;
            out_flags_reg[FLAG_POPPED]  <= res_valid_reg;
            out_flags_reg[FLAG_DROPPED] <= res_drop_reg;
            out_flags_reg[FLAG_EMPTY]   <= (count_reg == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_flags_reg;

endmodule

/* rtl/sorted_priority_queue.sv */
// channel  | dir | handshake          | payload
// s_       | in  | s_tvalid/s_tready  | s_tdata: item_value, priority_req; s_tuser: operation
// m_       | out | m_tvalid/m_tready  | m_tdata: popped_value; m_tuser flags (see port)
// cfg_     | in  | cfg_wr_en          | cfg_wr_data: ascending_order
//
// one word at a time; entries sit in a ring in a single-port-pair ram
// pop reads then takes the head entry, head push writes in front of the head; unused code,
// empty pop and dropped push go straight to the finish state; insert runs a read/compare loop from
// the head to the insert point, then a read/write loop shifting the tail up by one
// synchronous active-low reset empties the queue; the ram needs no clearing
// a stalled result holds the block in its finish state, and so the next word, until m_tready
module sorted_priority_queue import spq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [ENTRY_W-1:0] s_tdata,   // item_value [31:0], priority_req [63:32]
    input  logic [1:0]         s_tuser,   // operation [1:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [VALUE_W-1:0] m_tdata,   // popped_value [31:0]
    output logic [FLAGS_W-1:0] m_tuser,   // popped_valid [0], push_dropped [1], now_empty [2]
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data
);

    spq_cmd_t    cmd;
    spq_status_t status;

    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (op_t'(s_tuser)),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

/* rtl/spq_checker.sv */
module spq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        cfg_wr_en,
    input logic        cfg_wr_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one word in flight: no accept right after an accept
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while busy");

    // a result never both pops and drops
    a_pop_or_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("pop and drop in one result");

    // a dropped push means a full, so not empty, queue
    a_drop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[2])
        else $error("dropped push reported empty queue");

    // no popped entry means a zero value
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
        else $error("value without popped entry");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

/* dv/tb_sorted_priority_queue.sv */
module tb_sorted_priority_queue;

    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int      DEPTH       = 16;
    localparam int      SETTLE      = 2 * DEPTH + 8;
    localparam int      PHASE_WORDS = 208;
    localparam longint  CYCLE_LIMIT = 1_000_000;
    // unused operation code, the block must leave the queue alone
    localparam logic [1:0] OP_NONE  = 2'd3;

    // one expected result word, fields as carried on m_tdata / m_tuser
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               popped;
        logic               dropped;
        logic               empty;
    } result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [ENTRY_W-1:0] s_tdata;   // item_value [31:0], priority_req [63:32]
    logic [1:0]         s_tuser;   // operation [1:0]
    logic               m_tvalid;
    logic               m_tready;
    logic [VALUE_W-1:0] m_tdata;   // popped_value [31:0]
    logic [FLAGS_W-1:0] m_tuser;   // popped_valid [0], push_dropped [1], now_empty [2]
    logic               cfg_wr_en;
    logic               cfg_wr_data;

    int     hold_cycles = 0;
    bit     sink_random = 0;
    longint cycle_count = 0;

    // shadow copy of the queue, its order setting and the words still owed
    class sorted_queue_shadow;
        logic [VALUE_W-1:0] entry_val [DEPTH];
        logic [PRIO_W-1:0]  entry_pri [DEPTH];
        int      entry_cnt;
        bit      smallest_first;
        result_t pending_results[$];
        int      mismatches;
        int      results_seen;
        int      pops_with_data;
        int      pops_on_empty;
        int      dropped_pushes;

        function new();
            entry_cnt      = 0;
            smallest_first = 1'b1;
            mismatches     = 0;
            results_seen   = 0;
            pops_with_data = 0;
            pops_on_empty  = 0;
            dropped_pushes = 0;
        endfunction

        function void set_order(bit asc);
            smallest_first = asc;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // apply one accepted word and queue the result it must produce
        function void note_word(logic [1:0] op, logic [VALUE_W-1:0] val,
                                logic [PRIO_W-1:0] pri);
            result_t res;
            int      pos;
            res = '0;
            if (op == OP_POP) begin
                if (entry_cnt > 0) begin
                    res.value  = entry_val[0];
                    res.popped = 1'b1;
                    for (int k = 1; k < entry_cnt; k++) begin
                        entry_val[k-1] = entry_val[k];
                        entry_pri[k-1] = entry_pri[k];
                    end
                    entry_cnt--;
                    pops_with_data++;
                end else begin
                    pops_on_empty++;
                end
            end else if (op == OP_PUSH_HEAD || op == OP_INSERT) begin
                if (entry_cnt >= DEPTH) begin
                    res.dropped = 1'b1;
                    dropped_pushes++;
                end else begin
                    pos = 0;
                    // walk past entries that strictly precede the new priority
                    if (op == OP_INSERT) begin
                        while (pos < entry_cnt &&
                               (smallest_first ? (entry_pri[pos] < pri)
                                               : (entry_pri[pos] > pri)))
                            pos++;
                    end
                    for (int k = entry_cnt; k > pos; k--) begin
                        entry_val[k] = entry_val[k-1];
                        entry_pri[k] = entry_pri[k-1];
                    end
                    entry_val[pos] = val;
                    entry_pri[pos] = pri;
                    entry_cnt++;
                end
            end
            res.empty = (entry_cnt == 0);
            pending_results.push_back(res);
        endfunction

        function void report(string what, result_t want, result_t got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] mismatch, %s: expected value %h popped %b dropped %b empty %b",
                         $time, what, want.value, want.popped, want.dropped, want.empty);
                $display("    got value %h popped %b dropped %b empty %b",
                         got.value, got.popped, got.dropped, got.empty);
            end
        endfunction

        // compare one accepted result word against the oldest expectation
        function void check_result(logic [VALUE_W-1:0] data, logic [FLAGS_W-1:0] flags);
            result_t got;
            result_t want;
            got.value   = data;
            got.popped  = flags[FLAG_POPPED];
            got.dropped = flags[FLAG_DROPPED];
            got.empty   = flags[FLAG_EMPTY];
            results_seen++;
            if (pending_results.size() == 0) begin
                report("result word with nothing owed", '0, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.value !== want.value || got.popped !== want.popped ||
                got.dropped !== want.dropped || got.empty !== want.empty)
                report("field differs", want, got);
        endfunction

        function void close_out();
            if (pending_results.size() != 0) begin
                mismatches++;
                $display("%0d result words never arrived", pending_results.size());
            end
        endfunction
    endclass

    sorted_queue_shadow sb;

    sorted_priority_queue #(
        .QUEUE_DEPTH (DEPTH)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 4 ns clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // priorities: often small to force ties, sometimes extremes or full range
    function automatic logic [PRIO_W-1:0] pick_priority();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom_range(0, 7);
        else if (r == 5)
            return '0;
        else if (r == 6)
            return '1;
        else if (r == 7)
            return 32'hFFFF_FFF8 + $urandom_range(0, 7);
        return $urandom;
    endfunction

    // receiver: long hold when asked, else random stalls or always ready
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready = 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if (sink_random && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // offer one word and wait until it is taken
    task automatic send_word(input logic [1:0] op, input logic [VALUE_W-1:0] val,
                             input logic [PRIO_W-1:0] pri);
        @(negedge aclk);
        s_tuser  = op;
        s_tdata  = {pri, val};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(op, val, pri);
    endtask

    task automatic sender_gap();
        int n;
        n = pick_gap();
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // stop offering, wait for every owed word, then let the block settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_order(input bit asc);
        drain();
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = asc;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        sb.set_order(asc);
    endtask

    // random mix of operations, push_pct sets how full the queue tends to run
    task automatic random_phase(input int n, input int push_pct, input bit quiet);
        logic [1:0] op;
        int         r;
        sink_random = !quiet;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 2)
                op = OP_NONE;
            else if (r < 2 + push_pct)
                op = ($urandom_range(0, 3) == 0) ? OP_PUSH_HEAD : OP_INSERT;
            else
                op = OP_POP;
            send_word(op, $urandom, pick_priority());
            if (!quiet)
                sender_gap();
        end
    endtask

    initial begin
        int phases;
        sb          = new();
        phases      = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_POP;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        repeat (4) @(negedge aclk);

        // smallest priority first: empty cases, extremes, ties, head push
        write_order(1'b1);
        sink_random = 1'b1;
        send_word(OP_POP,       32'h0000_0000, 32'h0000_0000);
        send_word(OP_NONE,      32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_INSERT,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_INSERT,    32'h0000_0000, 32'h0000_0000);
        send_word(OP_INSERT,    32'hA5A5_0001, 32'h0000_0005);
        send_word(OP_INSERT,    32'hA5A5_0002, 32'h0000_0005);
        send_word(OP_PUSH_HEAD, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
        send_word(OP_INSERT,    32'h1234_5678, 32'h0000_0006);
        send_word(OP_NONE,      32'h0000_0000, 32'h0000_0000);

        // largest priority first, fill up and push into a full queue
        write_order(1'b0);
        send_word(OP_INSERT,    32'hC000_0001, 32'h0000_0003);
        send_word(OP_INSERT,    32'hC000_0002, 32'h0000_0003);
        send_word(OP_INSERT,    32'hC000_0003, 32'hFFFF_FFFF);
        send_word(OP_INSERT,    32'hC000_0004, 32'h0000_0000);
        send_word(OP_INSERT,    32'hC000_0005, 32'h0000_0064);
        send_word(OP_INSERT,    32'hC000_0006, 32'h0000_0064);
        send_word(OP_INSERT,    32'hC000_0007, 32'h0000_0007);
        send_word(OP_INSERT,    32'hC000_0008, 32'h0000_0001);
        send_word(OP_INSERT,    32'hC000_0009, 32'h8000_0000);
        send_word(OP_PUSH_HEAD, 32'hDEAD_0001, 32'h0000_0002);
        send_word(OP_INSERT,    32'hDEAD_0002, 32'h0000_0002);
        send_word(OP_POP,       32'h0000_0000, 32'h0000_0000);
        send_word(OP_POP,       32'h0000_0000, 32'h0000_0000);

        // random phases over both orders, one with a long receiver hold
        write_order(1'b1);
        random_phase(PHASE_WORDS, 70, 1'b0);
        write_order(1'b0);
        hold_cycles = 400;
        random_phase(PHASE_WORDS, 70, 1'b1);
        write_order(1'($urandom_range(0, 1)));
        random_phase(PHASE_WORDS, 35, 1'b0);
        write_order(1'b0);
        random_phase(PHASE_WORDS, 55, 1'b1);
        write_order(1'b1);
        random_phase(PHASE_WORDS, 55, 1'b0);
        write_order(1'($urandom_range(0, 1)));
        random_phase(PHASE_WORDS, 50, 1'b0);
        phases = 8;

        drain();
        sb.close_out();
        $display("covered %0d setting phases in both orders, %0d result words checked",
                 phases, sb.results_seen);
        $display("pops with data %0d, pops on empty %0d, pushes dropped when full %0d",
                 sb.pops_with_data, sb.pops_on_empty, sb.dropped_pushes);
        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches in total", sb.mismatches);
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/spq_pkg.sv
rtl/spq_ram.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
dv/tb_sorted_priority_queue.sv
